// File: sv/thick_segment_corners_defines.svh
// Assertion macros for the thick segment corner block.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef THICK_SEGMENT_CORNERS_DEFINES_SVH
`define THICK_SEGMENT_CORNERS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thick_segment_corners: check failed");

// Next-cycle implication, disabled during reset
`define TSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thick_segment_corners: check failed");

`endif

// File: sv/tsc_pkg.sv
// Shared types and constants for the thick segment corner block.
// No dependencies; imported by thick_segment_corners and its testbench.
`default_nettype none
package tsc_pkg;

  localparam int COORD_BITS = 16;
  localparam int WIDTH_BITS = 8;
  localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = 8'd10;

  // One segment transaction
  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } seg_t;

  // One corner result transaction
  typedef struct packed {
    logic signed [COORD_BITS-1:0] top_left_x;
    logic signed [COORD_BITS-1:0] top_left_y;
    logic signed [COORD_BITS-1:0] top_right_x;
    logic signed [COORD_BITS-1:0] top_right_y;
    logic signed [COORD_BITS-1:0] bottom_left_x;
    logic signed [COORD_BITS-1:0] bottom_left_y;
    logic signed [COORD_BITS-1:0] bottom_right_x;
    logic signed [COORD_BITS-1:0] bottom_right_y;
    logic                         degenerate;
  } corners_t;

endpackage
`default_nettype wire

// File: sv/tsc_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Standalone; used by thick_segment_corners.
`default_nettype none
module tsc_isqrt #(
  parameter int RW = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire logic [2*RW-1:0] op,
  output logic                 out_vld,
  output logic [RW-1:0]        root
);
  localparam int SW = 2 * RW;

  logic [SW-1:0] rem  [1:RW];
  logic [RW-1:0] rt   [1:RW];
  logic          vld  [1:RW];

  // Try one root bit per stage, from the top bit down
  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int K = RW - 1 - j;
    logic [SW-1:0] rem_in;
    logic [RW-1:0] rt_in;
    logic          vld_in;
    logic [SW-1:0] trial;

    // Take the operand at the first stage, the previous stage after that
    if (j == 0) begin : g_src
      assign rem_in = op;
      assign rt_in  = '0;
      assign vld_in = in_vld;
    end else begin : g_src
      assign rem_in = rem[j];
      assign rt_in  = rt[j];
      assign vld_in = vld[j];
    end

    assign trial = (SW'(rt_in) << (K + 1)) | (SW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld_in;
      end
      if (rem_in >= trial) begin
        rem[j+1] <= rem_in - trial;
        rt[j+1]  <= rt_in | (RW'(1) << K);
      end else begin
        rem[j+1] <= rem_in;
        rt[j+1]  <= rt_in;
      end
    end
  end

  assign out_vld = vld[RW];
  assign root    = rt[RW];
endmodule
`default_nettype wire

// File: sv/tsc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the quotient must fit in QW bits. Used by thick_segment_corners.
`default_nettype none
module tsc_div #(
  parameter int NW = 42,
  parameter int DW = 26,
  parameter int QW = 15
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               out_vld,
  output logic [QW-1:0]      quo
);
  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  logic [EW-1:0] rem [1:QW];
  logic [DW-1:0] dv  [1:QW];
  logic [QW-1:0] q   [1:QW];
  logic          vld [1:QW];

  // Subtract the shifted divisor where it fits, top quotient bit first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int I = QW - 1 - j;
    logic [EW-1:0] rem_in;
    logic [DW-1:0] dv_in;
    logic [QW-1:0] q_in;
    logic          vld_in;
    logic [EW-1:0] dsh;

    // Take the operands at the first stage, the previous stage after that
    if (j == 0) begin : g_src
      assign rem_in = EW'(num);
      assign dv_in  = den;
      assign q_in   = '0;
      assign vld_in = in_vld;
    end else begin : g_src
      assign rem_in = rem[j];
      assign dv_in  = dv[j];
      assign q_in   = q[j];
      assign vld_in = vld[j];
    end

    assign dsh = EW'(dv_in) << I;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld_in;
      end
      dv[j+1] <= dv_in;
      if (rem_in >= dsh) begin
        rem[j+1] <= rem_in - dsh;
        q[j+1]   <= q_in | (QW'(1) << I);
      end else begin
        rem[j+1] <= rem_in;
        q[j+1]   <= q_in;
      end
    end
  end

  assign out_vld = vld[QW];
  assign quo     = q[QW];
endmodule
`default_nettype wire

// File: sv/thick_segment_corners.sv
// Top level of the thick segment corner block: front end, corner stages, glue.
// Depends on tsc_pkg, tsc_isqrt, tsc_div and thick_segment_corners_defines.svh.
`default_nettype none
// Takes one segment per clock (busy stays low) and delivers its four rectangle
// corners as one transaction on corners, flagged by done for a single cycle,
// after stages 1 to 4, the square root pipeline (one root bit per stage),
// stage 5, the offset dividers (one quotient bit per stage), stage 6 and the
// stage 7 result register. The receiver cannot stall done; results must be
// taken as they come. Write line_width through the cfg channel only while no
// segment is in flight.
`include "thick_segment_corners_defines.svh"
module thick_segment_corners #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire tsc_pkg::seg_t               seg,
  output logic                             done,
  output tsc_pkg::corners_t                corners,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tsc_pkg::WIDTH_BITS-1:0] cfg_data
);
  import tsc_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int RW  = CB + 1 + F;            // root width
  localparam int SW  = 2 * RW;                // root operand width
  localparam int PW  = CB + 1 + WIDTH_BITS;   // magnitude times width
  localparam int NW  = CB + 10 + 2 * F;       // rounded numerator
  localparam int DW  = RW + 1;                // denominator 2*root
  localparam int QW  = F + 7;                 // offset magnitude
  localparam int OW  = QW + 1;                // signed offset
  localparam int VW  = CB + F + 2;            // corner before rounding
  localparam int LAT = 7 + RW + QW;
  localparam int S1W = 4 * CB + 3 + 2 * PW;   // sidecar with products
  localparam int S2W = 4 * CB + 3;            // sidecar without products

  // Configuration register
  logic [WIDTH_BITS-1:0] line_width;
  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_width <= cfg_data;
    end
  end

  // Stage 1: capture the segment
  logic p1_vld;
  seg_t p1_seg;
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= start && !busy;
    end
    p1_seg <= seg;
  end

  // Stage 2: deltas, magnitudes and signs
  logic signed [CB:0] dx, dy;
  assign dx = $signed({p1_seg.end_x[CB-1], p1_seg.end_x})
            - $signed({p1_seg.start_x[CB-1], p1_seg.start_x});
  assign dy = $signed({p1_seg.end_y[CB-1], p1_seg.end_y})
            - $signed({p1_seg.start_y[CB-1], p1_seg.start_y});

  logic        p2_vld;
  seg_t        p2_seg;
  logic [CB:0] p2_adx, p2_ady;
  logic        p2_dxn, p2_dyn, p2_deg;
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
    p2_seg <= p1_seg;
    p2_adx <= dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
    p2_ady <= dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);
    p2_dxn <= dx[CB];
    p2_dyn <= dy[CB];
    p2_deg <= (dx == '0) && (dy == '0);
  end

  // Stage 3: squares and width products
  logic            p3_vld;
  seg_t            p3_seg;
  logic [2*CB+1:0] p3_sqx, p3_sqy;
  logic [PW-1:0]   p3_pwx, p3_pwy;
  logic            p3_dxn, p3_dyn, p3_deg;
  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else begin
      p3_vld <= p2_vld;
    end
    p3_seg <= p2_seg;
    p3_sqx <= p2_adx * p2_adx;
    p3_sqy <= p2_ady * p2_ady;
    p3_pwx <= p2_ady * line_width;   // feeds the x offset
    p3_pwy <= p2_adx * line_width;   // feeds the y offset
    p3_dxn <= p2_dxn;
    p3_dyn <= p2_dyn;
    p3_deg <= p2_deg;
  end

  // Stage 4: squared length with fraction bits
  logic [2*CB+2:0] sum_sq;
  assign sum_sq = (2*CB+3)'(p3_sqx) + (2*CB+3)'(p3_sqy);

  logic           p4_vld;
  logic [SW-1:0]  p4_op;
  logic [S1W-1:0] p4_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else begin
      p4_vld <= p3_vld;
    end
    p4_op   <= SW'(sum_sq[2*CB+1:0]) << (2 * F);
    p4_side <= {p3_seg, p3_dxn, p3_dyn, p3_deg, p3_pwx, p3_pwy};
  end

  // Square root, with the sidecar delayed alongside
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  tsc_isqrt #(.RW(RW)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p4_vld),
    .op      (p4_op),
    .out_vld (sq_vld),
    .root    (sq_root)
  );

  logic [S1W-1:0] side1 [RW];
  always_ff @(posedge clk) begin
    side1[0] <= p4_side;
    for (int i = 1; i < RW; i++) begin
      side1[i] <= side1[i-1];
    end
  end

  // Stage 5: numerators with the half-denominator added, denominator
  logic [PW-1:0] s1_pwx, s1_pwy;
  logic [S2W-1:0] s1_rest;
  assign {s1_rest, s1_pwx, s1_pwy} = side1[RW-1];

  logic           p5_vld;
  logic [NW-1:0]  p5_numx, p5_numy;
  logic [DW-1:0]  p5_den;
  logic [S2W-1:0] p5_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      p5_vld <= 1'b0;
    end else begin
      p5_vld <= sq_vld;
    end
    p5_numx <= (NW'(s1_pwx) << (2 * F)) + NW'(sq_root);
    p5_numy <= (NW'(s1_pwy) << (2 * F)) + NW'(sq_root);
    p5_den  <= {sq_root, 1'b0};
    p5_side <= s1_rest;
  end

  // Offset dividers
  logic          dv_vld;
  logic [QW-1:0] qx, qy;
  tsc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p5_vld),
    .num     (p5_numx),
    .den     (p5_den),
    .out_vld (dv_vld),
    .quo     (qx)
  );
  tsc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p5_vld),
    .num     (p5_numy),
    .den     (p5_den),
    .out_vld (),
    .quo     (qy)
  );

  logic [S2W-1:0] side2 [QW];
  always_ff @(posedge clk) begin
    side2[0] <= p5_side;
    for (int i = 1; i < QW; i++) begin
      side2[i] <= side2[i-1];
    end
  end

  // Stage 6: signed offsets and unrounded corners
  seg_t s2_seg;
  logic s2_dxn, s2_dyn, s2_deg;
  assign {s2_seg, s2_dxn, s2_dyn, s2_deg} = side2[QW-1];

  logic signed [OW-1:0] ox, oy;
  assign ox = s2_dyn ? $signed({1'b0, qx}) : -$signed({1'b0, qx});
  assign oy = s2_dxn ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  function automatic logic signed [VW-1:0] scale_add(
    input logic signed [CB-1:0] c,
    input logic signed [OW-1:0] off,
    input logic                 sub
  );
    logic signed [VW-1:0] cs;
    logic signed [VW-1:0] os;
    cs = $signed({{(VW-CB){c[CB-1]}}, c}) <<< F;
    os = $signed({{(VW-OW){off[OW-1]}}, off});
    return sub ? cs - os : cs + os;
  endfunction

  logic                 p6_vld, p6_deg;
  logic signed [VW-1:0] p6_v [8];
  always_ff @(posedge clk) begin
    if (rst) begin
      p6_vld <= 1'b0;
    end else begin
      p6_vld <= dv_vld;
    end
    p6_deg  <= s2_deg;
    p6_v[0] <= scale_add(s2_seg.start_x, ox, 1'b0);
    p6_v[1] <= scale_add(s2_seg.start_y, oy, 1'b0);
    p6_v[2] <= scale_add(s2_seg.end_x,   ox, 1'b0);
    p6_v[3] <= scale_add(s2_seg.end_y,   oy, 1'b0);
    p6_v[4] <= scale_add(s2_seg.start_x, ox, 1'b1);
    p6_v[5] <= scale_add(s2_seg.start_y, oy, 1'b1);
    p6_v[6] <= scale_add(s2_seg.end_x,   ox, 1'b1);
    p6_v[7] <= scale_add(s2_seg.end_y,   oy, 1'b1);
  end

  // Round half away from zero, then saturate to the coordinate range
  function automatic logic signed [CB-1:0] round_sat(input logic signed [VW-1:0] v);
    logic [VW-1:0]        mag;
    logic [VW-1:0]        rm;
    logic signed [VW:0]   rs;
    logic signed [VW:0]   hi;
    logic signed [VW:0]   lo;
    mag = v[VW-1] ? VW'(-v) : VW'(v);
    rm  = (mag + (VW'(1) << (F - 1))) >> F;
    rs  = v[VW-1] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
    hi  = $signed((VW+1)'((1 << (CB - 1)) - 1));
    lo  = -hi - (VW+1)'(1);
    if (rs > hi) begin
      return CB'(hi);
    end else if (rs < lo) begin
      return CB'(lo);
    end
    return CB'(rs);
  endfunction

  // Stage 7: result register and strobe
  logic signed [CB-1:0] rc [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rc[i] = p6_deg ? '0 : round_sat(p6_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p6_vld;
    end
    corners.top_left_x     <= rc[0];
    corners.top_left_y     <= rc[1];
    corners.top_right_x    <= rc[2];
    corners.top_right_y    <= rc[3];
    corners.bottom_left_x  <= rc[4];
    corners.bottom_left_y  <= rc[5];
    corners.bottom_right_x <= rc[6];
    corners.bottom_right_y <= rc[7];
    corners.degenerate     <= p6_deg;
  end

  // Checks
  `TSC_ASSERT_IMP(a_deg_zero, done && corners.degenerate,
    corners.top_left_x == '0 && corners.bottom_right_y == '0)
  `TSC_ASSERT_IMP(a_latency, done, $past(start, LAT))
  `TSC_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, line_width == $past(cfg_data))

endmodule
`default_nettype wire

// File: tb/sv/tb_thick_segment_corners.sv
// Self-checking testbench for thick_segment_corners: segment to rectangle corners.
// Depends on tsc_pkg and the thick_segment_corners RTL with its submodules and defines.
`timescale 1ns / 100ps
`default_nettype none
module tb_thick_segment_corners;
  import tsc_pkg::*;

  localparam int FRAC = 8;
  localparam int PIPE_DELAY = 47;
  localparam int RANDOM_SEGS = 1330;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  seg_t seg = '0;
  logic done;
  corners_t corners;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WIDTH_BITS-1:0] cfg_data = '0;

  corners_t expected_corners[$];
  logic [WIDTH_BITS-1:0] width_shadow = LINE_WIDTH_RESET;
  int seg_count = 0;
  int degenerate_count = 0;
  int mismatch_count = 0;
  int width_writes = 0;

  thick_segment_corners #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .seg(seg),
    .done(done), .corners(corners),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Exact integer square root, bit pair at a time
  function automatic longint unsigned int_sqrt(longint unsigned op);
    longint unsigned root;
    longint unsigned bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > op) bitpos >>= 2;
    while (bitpos != 0) begin
      if (op >= root + bitpos) begin
        op -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  // Signed offset, rounded half away from zero on the magnitude
  function automatic longint offset_of(longint d, longint unsigned w,
                                       longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? -d : d;
    q = (mag * w * (64'd1 << (2 * FRAC)) + den / 2) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Round fixed-point corner to integer, then clamp to coordinate range
  function automatic logic [COORD_BITS-1:0] round_corner(longint c, longint off);
    longint v;
    longint r;
    longint hi;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    v = c * (64'sd1 <<< FRAC) + off;
    if (v >= 0) r = (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    else r = -((-v + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic corners_t segment_corners(seg_t s, logic [WIDTH_BITS-1:0] w);
    corners_t c;
    longint sx, sy, ex, ey, dx, dy, ox, oy;
    longint unsigned len2, len_fx;
    sx = s.start_x; sy = s.start_y; ex = s.end_x; ey = s.end_y;
    dx = ex - sx;
    dy = ey - sy;
    c = '0;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) begin
      c.degenerate = 1'b1;
      return c;
    end
    len_fx = int_sqrt(len2 << (2 * FRAC));
    ox = -offset_of(dy, w, 2 * len_fx);
    oy = offset_of(dx, w, 2 * len_fx);
    c.top_left_x = round_corner(sx, ox);
    c.top_left_y = round_corner(sy, oy);
    c.top_right_x = round_corner(ex, ox);
    c.top_right_y = round_corner(ey, oy);
    c.bottom_left_x = round_corner(sx, -ox);
    c.bottom_left_y = round_corner(sy, -oy);
    c.bottom_right_x = round_corner(ex, -ox);
    c.bottom_right_y = round_corner(ey, -oy);
    return c;
  endfunction

  task automatic report_mismatch(string field, logic [COORD_BITS-1:0] got,
                                 logic [COORD_BITS-1:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field,
             $signed(got), $signed(want));
    mismatch_count++;
  endtask

  // Compare each corner transaction with the oldest pending expectation
  always @(posedge clk) begin
    corners_t want;
    if (!rst && done) begin
      if (expected_corners.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
      end else begin
        want = expected_corners.pop_front();
        if (corners.top_left_x !== want.top_left_x)
          report_mismatch("top_left_x", corners.top_left_x, want.top_left_x);
        if (corners.top_left_y !== want.top_left_y)
          report_mismatch("top_left_y", corners.top_left_y, want.top_left_y);
        if (corners.top_right_x !== want.top_right_x)
          report_mismatch("top_right_x", corners.top_right_x, want.top_right_x);
        if (corners.top_right_y !== want.top_right_y)
          report_mismatch("top_right_y", corners.top_right_y, want.top_right_y);
        if (corners.bottom_left_x !== want.bottom_left_x)
          report_mismatch("bottom_left_x", corners.bottom_left_x, want.bottom_left_x);
        if (corners.bottom_left_y !== want.bottom_left_y)
          report_mismatch("bottom_left_y", corners.bottom_left_y, want.bottom_left_y);
        if (corners.bottom_right_x !== want.bottom_right_x)
          report_mismatch("bottom_right_x", corners.bottom_right_x,
                          want.bottom_right_x);
        if (corners.bottom_right_y !== want.bottom_right_y)
          report_mismatch("bottom_right_y", corners.bottom_right_y,
                          want.bottom_right_y);
        if (corners.degenerate !== want.degenerate)
          report_mismatch("degenerate", corners.degenerate, want.degenerate);
      end
    end
  end

  // Issue one segment; hold start high until accepted, then idle at random
  task automatic send_seg(seg_t s);
    int gap;
    seg <= s;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_corners.push_back(segment_corners(s, width_shadow));
    seg_count++;
    if (s.start_x == s.end_x && s.start_y == s.end_y) degenerate_count++;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the pipeline, then wait out its depth
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (expected_corners.size() != 0) @(posedge clk);
    repeat (PIPE_DELAY + 4) @(posedge clk);
  endtask

  task automatic write_width(logic [WIDTH_BITS-1:0] w);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_shadow = w;
    width_writes++;
  endtask

  function automatic seg_t mk_seg(int sx, int sy, int ex, int ey);
    seg_t s;
    s.start_x = sx[COORD_BITS-1:0];
    s.start_y = sy[COORD_BITS-1:0];
    s.end_x = ex[COORD_BITS-1:0];
    s.end_y = ey[COORD_BITS-1:0];
    return s;
  endfunction

  // Short segments anywhere, fully random ones, some near the range edges, a few zero-length
  function automatic seg_t random_seg();
    seg_t s;
    int kind;
    s = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      s.end_x = s.start_x;
      s.end_y = s.start_y;
    end else if (kind <= 4) begin
      s.end_x = s.start_x + COORD_BITS'($signed($urandom_range(0, 64)) - 32);
      s.end_y = s.start_y + COORD_BITS'($signed($urandom_range(0, 64)) - 32);
    end else if (kind == 5) begin
      s.start_x = $urandom_range(0, 1) ? 16'sh7ffe : 16'sh8001;
      s.end_y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return s;
  endfunction

  task automatic test_directed();
    send_seg(mk_seg(0, 0, 0, 0));
    send_seg(mk_seg(100, -200, 100, -200));
    send_seg(mk_seg(0, 0, 100, 0));
    send_seg(mk_seg(0, 0, 0, 100));
    send_seg(mk_seg(0, 0, -100, 0));
    send_seg(mk_seg(0, 0, 0, -100));
    send_seg(mk_seg(0, 0, 3, 4));
    send_seg(mk_seg(-5, 7, 8, -9));
    send_seg(mk_seg(-32768, -32768, 32767, 32767));
    send_seg(mk_seg(32767, -32768, -32768, 32767));
    send_seg(mk_seg(32767, 32767, 32767, 0));
    send_seg(mk_seg(-32768, -32768, 0, -32768));
    send_seg(mk_seg(32767, 32767, 32767, 32767));
    send_seg(mk_seg(1, 1, 2, 2));
  endtask

  task automatic test_widths();
    write_width(8'd0);
    send_seg(mk_seg(10, 10, 50, 80));
    send_seg(mk_seg(-32768, 32767, 32767, -32768));
    write_width(8'd255);
    test_directed();
    write_width(8'd1);
    send_seg(mk_seg(0, 0, 1, 0));
    send_seg(mk_seg(0, 0, 1, 1));
    send_seg(mk_seg(7, -3, 7, 2));
  endtask

  task automatic test_random();
    for (int i = 0; i < RANDOM_SEGS; i++) begin
      if (i % 200 == 199) begin
        if (i % 400 == 399) drain_pipe();
        else write_width(8'($urandom));
      end
      send_seg(random_seg());
    end
    drain_pipe();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_widths();
    test_random();
    $display("Covered %0d segments (%0d zero-length) across %0d width settings.",
             seg_count, degenerate_count, width_writes + 1);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d transactions pending", expected_corners.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
